// File: src/grmd_pkg.sv
// Shared types, constants and tables for the grid ray march distance block.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package grmd_pkg;

   localparam int GRID_COLS = 32;
   localparam int GRID_ROWS = 32;
   localparam int MAP_DEPTH = GRID_ROWS * GRID_COLS;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   localparam int ANGLE_W = 13;
   localparam int TURN    = 5760;
   localparam int QUARTER = 1440;
   localparam int R_W     = 11;

   localparam int MUL_W  = 31;
   localparam int PROD_W = 2 * MUL_W;
   localparam int Q30    = 30;

   localparam logic [MUL_W-1:0] C1 = 31'd1686629713;
   localparam logic [MUL_W-1:0] C3 = 31'd693598668;
   localparam logic [MUL_W-1:0] C5 = 31'd85569306;
   localparam logic [MUL_W-1:0] C7 = 31'd5026995;
   localparam logic [MUL_W-1:0] C9 = 31'd172272;

   localparam int RDIV        = QUARTER / 32;
   localparam int FRAC_SHIFT  = Q30 - 5;
   localparam int FRAC_BIAS   = (QUARTER / 2) / 32;
   localparam int FRAC_W      = FRAC_SHIFT;
   localparam int FRAC_AW     = $clog2(RDIV);
   localparam int A_W         = MUL_W - FRAC_W;
   localparam int RECIP       = 23302;
   localparam int RECIP_SHIFT = 20;

   localparam int MAG_W  = 17;
   localparam int SINE_W = MAG_W + 1;
   localparam int MAG_SHIFT = Q30 - 16;

   localparam int ACC_W      = 25;
   localparam int CELL_LSB   = 16;
   localparam int CELL_W     = 8;
   localparam int ROUND_HALF = 32768;

   localparam int   STEPS_W         = 6;
   localparam logic [STEPS_W-1:0] MAX_STEPS_RESET = 6'd30;
   localparam int   CSR_AW          = 3;
   localparam int   CSR_DW          = 32;
   localparam logic REG_MAX_STEPS   = 1'b0;

   typedef logic [RDIV-1:0][FRAC_W-1:0] tfrac_table_type;

   function automatic tfrac_table_type make_tfrac();
      tfrac_table_type tab;
      for (int b = 0; b < RDIV; b++) begin
         tab[b] = FRAC_W'(((longint'(b) << FRAC_SHIFT) + longint'(FRAC_BIAS)) / RDIV);
      end
      return tab;
   endfunction

   localparam tfrac_table_type TFRAC = make_tfrac();

   typedef struct packed {
      logic               start;
      logic [ANGLE_W-1:0] angle;
   } sine_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [SINE_W-1:0] value;
   } sine_rsp_type;

endpackage

`default_nettype wire

// File: src/grmd_req_if.sv
// Input channel of the grid ray march block: valid, ready and one item.
// Depends on nothing.
`default_nettype none

interface grmd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [4:0] cell_row;
   logic [4:0] cell_col;
   logic       is_wall;
   logic [8:0] start_x;
   logic [8:0] start_y;
   logic [12:0] ray_angle;

   modport source (output valid, kind, cell_row, cell_col, is_wall, start_x, start_y,
                   ray_angle, input ready);
   modport sink (input valid, kind, cell_row, cell_col, is_wall, start_x, start_y,
                 ray_angle, output ready);
endinterface

`default_nettype wire

// File: src/grmd_rsp_if.sv
// Result channel of the grid ray march block: valid, ready and one result.
// Depends on nothing.
`default_nettype none

interface grmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] distance;
   logic       hit_wall;
   logic       out_of_grid;

   modport source (output valid, distance, hit_wall, out_of_grid, input ready);
   modport sink (input valid, distance, hit_wall, out_of_grid, output ready);
endinterface

`default_nettype wire

// File: src/grmd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module grmd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: src/grmd_csr.sv
// APB-style configuration register file holding the max_steps register.
// Depends on grmd_pkg.
`default_nettype none

module grmd_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [grmd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [grmd_pkg::CSR_DW-1:0]   csr_pwdata,
   output      logic [grmd_pkg::CSR_DW-1:0]   csr_prdata,
   output      logic                          csr_pready,
   output      logic [grmd_pkg::STEPS_W-1:0]  max_steps
);

   logic [grmd_pkg::STEPS_W-1:0] max_steps_ff;
   logic [grmd_pkg::STEPS_W-1:0] max_steps_in;
   logic                         reg_sel;
   logic                         wr_strobe;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[2] == grmd_pkg::REG_MAX_STEPS);
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_steps_in = max_steps_ff;
      if (wr_strobe && reg_sel) begin
         max_steps_in = csr_pwdata[grmd_pkg::STEPS_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel) begin
         csr_prdata = grmd_pkg::CSR_DW'(max_steps_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_steps_ff <= grmd_pkg::MAX_STEPS_RESET;
      end else begin
         max_steps_ff <= max_steps_in;
      end
   end

   assign max_steps = max_steps_ff;

endmodule

`default_nettype wire

// File: src/grmd_sine.sv
// Iterative sine unit: one shared 31 x 31 multiplier under a small sequencer
// evaluates the Q30 polynomial and returns the sine in Q16. Depends on grmd_pkg.
`default_nettype none

module grmd_sine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire grmd_pkg::sine_req_type sine_req,
   output      grmd_pkg::sine_rsp_type sine_rsp
);

   typedef enum logic [2:0] {
      IDLE,
      QUAD,
      RMUL,
      RUSE,
      FRAC,
      PMUL,
      PUSE
   } state_type;

   localparam logic [2:0] LAST_J = 3'd5;

   state_type                         state_ff, state_in;
   logic [grmd_pkg::ANGLE_W-1:0]      ang_ff, ang_in;
   logic [grmd_pkg::R_W-1:0]          r_ff, r_in;
   logic                              neg_ff, neg_in;
   logic [grmd_pkg::A_W-1:0]          a_ff, a_in;
   logic [grmd_pkg::MUL_W-1:0]        t_ff, t_in;
   logic [grmd_pkg::MUL_W-1:0]        u_ff, u_in;
   logic [grmd_pkg::MUL_W-1:0]        p_ff, p_in;
   logic [2:0]                        j_ff, j_in;
   logic [grmd_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic                              done_ff, done_in;
   logic signed [grmd_pkg::SINE_W-1:0] value_ff, value_in;

   logic [grmd_pkg::MUL_W-1:0]        op_a, op_b;
   logic [grmd_pkg::PROD_W-1:0]       prod_round;
   logic [grmd_pkg::MUL_W-1:0]        rnd;
   logic [1:0]                        quad;
   logic [grmd_pkg::ANGLE_W-1:0]      quad_base;
   logic [grmd_pkg::R_W-1:0]          r_raw;
   logic [grmd_pkg::R_W-1:0]          b_full;
   logic [grmd_pkg::FRAC_AW-1:0]      b_idx;
   logic [grmd_pkg::MUL_W:0]          mag_sum;
   logic [grmd_pkg::MAG_W-1:0]        mag;

   always_comb begin
      if (ang_ff >= grmd_pkg::ANGLE_W'(3 * grmd_pkg::QUARTER)) begin
         quad = 2'd3;
      end else if (ang_ff >= grmd_pkg::ANGLE_W'(2 * grmd_pkg::QUARTER)) begin
         quad = 2'd2;
      end else if (ang_ff >= grmd_pkg::ANGLE_W'(grmd_pkg::QUARTER)) begin
         quad = 2'd1;
      end else begin
         quad = 2'd0;
      end
      quad_base = grmd_pkg::ANGLE_W'(quad) * grmd_pkg::ANGLE_W'(grmd_pkg::QUARTER);
      r_raw     = grmd_pkg::R_W'(ang_ff - quad_base);
   end

   always_comb begin
      op_a = p_ff;
      op_b = p_ff;
      if (state_ff == RMUL) begin
         op_a = grmd_pkg::MUL_W'(r_ff);
         op_b = grmd_pkg::MUL_W'(grmd_pkg::RECIP);
      end else begin
         unique case (j_ff)
            3'd0: begin
               op_a = t_ff;
               op_b = t_ff;
            end
            3'd1: begin
               op_a = u_ff;
               op_b = grmd_pkg::C9;
            end
            3'd2, 3'd3, 3'd4: begin
               op_a = u_ff;
               op_b = p_ff;
            end
            default: begin
               op_a = t_ff;
               op_b = p_ff;
            end
         endcase
      end
      prod_in    = grmd_pkg::PROD_W'(op_a) * grmd_pkg::PROD_W'(op_b);
      prod_round = prod_ff + (grmd_pkg::PROD_W'(1) << (grmd_pkg::Q30 - 1));
      rnd        = prod_round[grmd_pkg::Q30 +: grmd_pkg::MUL_W];
      b_full     = r_ff - grmd_pkg::R_W'(a_ff) * grmd_pkg::R_W'(grmd_pkg::RDIV);
      b_idx      = b_full[grmd_pkg::FRAC_AW-1:0];
      mag_sum    = (grmd_pkg::MUL_W + 1)'(rnd)
                   + ((grmd_pkg::MUL_W + 1)'(1) << (grmd_pkg::MAG_SHIFT - 1));
      mag        = mag_sum[grmd_pkg::MAG_SHIFT +: grmd_pkg::MAG_W];
   end

   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      r_in     = r_ff;
      neg_in   = neg_ff;
      a_in     = a_ff;
      t_in     = t_ff;
      u_in     = u_ff;
      p_in     = p_ff;
      j_in     = j_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      unique case (state_ff)
         IDLE: begin
            if (sine_req.start) begin
               if (sine_req.angle >= grmd_pkg::ANGLE_W'(grmd_pkg::TURN)) begin
                  ang_in = sine_req.angle - grmd_pkg::ANGLE_W'(grmd_pkg::TURN);
               end else begin
                  ang_in = sine_req.angle;
               end
               state_in = QUAD;
            end
         end
         QUAD: begin
            r_in     = quad[0] ? grmd_pkg::R_W'(grmd_pkg::QUARTER) - r_raw : r_raw;
            neg_in   = quad[1];
            state_in = RMUL;
         end
         RMUL: begin
            state_in = RUSE;
         end
         RUSE: begin
            a_in     = prod_ff[grmd_pkg::RECIP_SHIFT +: grmd_pkg::A_W];
            state_in = FRAC;
         end
         FRAC: begin
            t_in     = {a_ff, grmd_pkg::TFRAC[b_idx]};
            j_in     = 3'd0;
            state_in = PMUL;
         end
         PMUL: begin
            state_in = PUSE;
         end
         PUSE: begin
            state_in = PMUL;
            j_in     = j_ff + 3'd1;
            unique case (j_ff)
               3'd0: u_in = rnd;
               3'd1: p_in = grmd_pkg::C7 - rnd;
               3'd2: p_in = grmd_pkg::C5 - rnd;
               3'd3: p_in = grmd_pkg::C3 - rnd;
               3'd4: p_in = grmd_pkg::C1 - rnd;
               default: begin
                  value_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                  done_in  = 1'b1;
                  state_in = IDLE;
               end
            endcase
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ang_ff   <= ang_in;
      r_ff     <= r_in;
      neg_ff   <= neg_in;
      a_ff     <= a_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      p_ff     <= p_in;
      j_ff     <= j_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end

   assign sine_rsp.done  = done_ff;
   assign sine_rsp.value = value_ff;

`ifndef NO_ASSERTIONS
   a_done_single : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("sine done held for more than one cycle");

   a_done_from_last : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == PUSE && j_ff == LAST_J))
      else $error("sine done without finishing the polynomial");
`endif

endmodule

`default_nettype wire

// File: src/grid_ray_march_distance_core.sv
// Top level of the grid ray march distance block: wall map, ray sequencer,
// result register. Depends on grmd_pkg, grmd_req_if, grmd_rsp_if, grmd_ram,
// grmd_csr and grmd_sine.
//
// After reset the block clears all GRID_ROWS*GRID_COLS cells of its wall map
// (1024 at the default size), one cell per cycle, and takes no item during
// that time. A write item gives no result. A cast item runs two sine
// evaluations, sine then cosine, on the shared multiplier of the sine unit,
// then samples n cells (at most max_steps+1), each step split into address
// generation and the registered map read. The result waits in an output
// register, so the next item is taken once the cast has been placed there.
`default_nettype none

module grid_ray_march_distance_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   grmd_req_if.sink                         req_ch,
   grmd_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [grmd_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [grmd_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [grmd_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                        csr_pready
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      SIN_GO,
      SIN_WAIT,
      COS_GO,
      COS_WAIT,
      STEP_ADDR,
      STEP_READ,
      DONE
   } state_type;

   localparam int ADDR_CALC_W = 2 * (grmd_pkg::CELL_W + 1);

   function automatic logic [grmd_pkg::MAP_AW-1:0] map_addr(
      input logic [grmd_pkg::CELL_W:0] row,
      input logic [grmd_pkg::CELL_W:0] col
   );
      logic [ADDR_CALC_W-1:0] full;
      full = ADDR_CALC_W'(row) * ADDR_CALC_W'(grmd_pkg::GRID_COLS) + ADDR_CALC_W'(col);
      return full[grmd_pkg::MAP_AW-1:0];
   endfunction

   state_type                            state_ff, state_in;
   logic [grmd_pkg::MAP_AW-1:0]          clr_ff, clr_in;
   logic [grmd_pkg::ANGLE_W-1:0]         ang_ff, ang_in;
   logic signed [grmd_pkg::ACC_W-1:0]    px_ff, px_in;
   logic signed [grmd_pkg::ACC_W-1:0]    py_ff, py_in;
   logic signed [grmd_pkg::SINE_W-1:0]   s_ff, s_in;
   logic signed [grmd_pkg::SINE_W-1:0]   c_ff, c_in;
   logic [grmd_pkg::STEPS_W-1:0]         k_ff, k_in;
   logic [grmd_pkg::STEPS_W-1:0]         dist_ff, dist_in;
   logic                                 hit_ff, hit_in;
   logic                                 oog_ff, oog_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [grmd_pkg::STEPS_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic                                 rsp_hit_ff, rsp_hit_in;
   logic                                 rsp_oog_ff, rsp_oog_in;

   logic [grmd_pkg::STEPS_W-1:0]         max_steps;
   grmd_pkg::sine_req_type               sine_req;
   grmd_pkg::sine_rsp_type               sine_rsp;
   logic [grmd_pkg::ANGLE_W-1:0]         ang_mod;
   logic signed [grmd_pkg::ACC_W-1:0]    vx, vy;
   logic [grmd_pkg::CELL_W:0]            cx, cy;
   logic                                 x_out, y_out;
   logic [grmd_pkg::STEPS_W-1:0]         limit_dist;
   logic                                 req_xfer;
   logic                                 wr_in_grid;
   logic                                 ram_wr_en;
   logic [grmd_pkg::MAP_AW-1:0]          ram_wr_addr;
   logic                                 ram_wr_data;
   logic [grmd_pkg::MAP_AW-1:0]          ram_rd_addr;
   logic                                 ram_rd_data;

   grmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_steps   (max_steps)
   );

   grmd_sine u_sine (
      .clock    (clock),
      .reset    (reset),
      .sine_req (sine_req),
      .sine_rsp (sine_rsp)
   );

   grmd_ram #(
      .WIDTH (1),
      .DEPTH (grmd_pkg::MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      if (ang_ff >= grmd_pkg::ANGLE_W'(grmd_pkg::TURN)) begin
         ang_mod = ang_ff - grmd_pkg::ANGLE_W'(grmd_pkg::TURN);
      end else begin
         ang_mod = ang_ff;
      end
      sine_req.start = (state_ff == SIN_GO) || (state_ff == COS_GO);
      sine_req.angle = (state_ff == COS_GO)
                       ? ang_mod + grmd_pkg::ANGLE_W'(grmd_pkg::QUARTER) : ang_ff;
   end

   always_comb begin
      vx    = px_ff + grmd_pkg::ACC_W'(grmd_pkg::ROUND_HALF);
      vy    = py_ff + grmd_pkg::ACC_W'(grmd_pkg::ROUND_HALF);
      cx    = {1'b0, vx[grmd_pkg::CELL_LSB +: grmd_pkg::CELL_W]};
      cy    = {1'b0, vy[grmd_pkg::CELL_LSB +: grmd_pkg::CELL_W]};
      x_out = vx[grmd_pkg::ACC_W-1] || (vx == '0)
              || (cx >= (grmd_pkg::CELL_W + 1)'(grmd_pkg::GRID_COLS));
      y_out = vy[grmd_pkg::ACC_W-1] || (vy == '0)
              || (cy >= (grmd_pkg::CELL_W + 1)'(grmd_pkg::GRID_ROWS));
      ram_rd_addr = map_addr(cy, cx);
      limit_dist  = (max_steps == '1) ? max_steps : max_steps + grmd_pkg::STEPS_W'(1);
   end

   always_comb begin
      wr_in_grid = ((grmd_pkg::CELL_W + 1)'(req_ch.cell_row)
                    < (grmd_pkg::CELL_W + 1)'(grmd_pkg::GRID_ROWS))
                   && ((grmd_pkg::CELL_W + 1)'(req_ch.cell_col)
                    < (grmd_pkg::CELL_W + 1)'(grmd_pkg::GRID_COLS));
      if (state_ff == CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = 1'b0;
      end else begin
         ram_wr_en   = req_xfer && !req_ch.kind && wr_in_grid;
         ram_wr_addr = map_addr((grmd_pkg::CELL_W + 1)'(req_ch.cell_row),
                                (grmd_pkg::CELL_W + 1)'(req_ch.cell_col));
         ram_wr_data = req_ch.is_wall;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ang_in       = ang_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      dist_in      = dist_ff;
      hit_in       = hit_ff;
      oog_in       = oog_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_oog_in   = rsp_oog_ff;
      unique case (state_ff)
         CLEAR: begin
            clr_in = clr_ff + grmd_pkg::MAP_AW'(1);
            if (clr_ff == grmd_pkg::MAP_AW'(grmd_pkg::MAP_DEPTH - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_xfer && req_ch.kind) begin
               ang_in   = req_ch.ray_angle;
               px_in    = grmd_pkg::ACC_W'({req_ch.start_x, 12'd0});
               py_in    = grmd_pkg::ACC_W'({req_ch.start_y, 12'd0});
               k_in     = '0;
               state_in = SIN_GO;
            end
         end
         SIN_GO: begin
            state_in = SIN_WAIT;
         end
         SIN_WAIT: begin
            if (sine_rsp.done) begin
               s_in     = sine_rsp.value;
               state_in = COS_GO;
            end
         end
         COS_GO: begin
            state_in = COS_WAIT;
         end
         COS_WAIT: begin
            if (sine_rsp.done) begin
               c_in     = sine_rsp.value;
               state_in = STEP_ADDR;
            end
         end
         STEP_ADDR: begin
            if (x_out || y_out) begin
               dist_in  = k_ff;
               hit_in   = 1'b0;
               oog_in   = 1'b1;
               state_in = DONE;
            end else begin
               state_in = STEP_READ;
            end
         end
         STEP_READ: begin
            if (ram_rd_data) begin
               dist_in  = k_ff;
               hit_in   = 1'b1;
               oog_in   = 1'b0;
               state_in = DONE;
            end else if (k_ff == max_steps) begin
               dist_in  = limit_dist;
               hit_in   = 1'b0;
               oog_in   = 1'b0;
               state_in = DONE;
            end else begin
               k_in     = k_ff + grmd_pkg::STEPS_W'(1);
               px_in    = px_ff + grmd_pkg::ACC_W'(s_ff);
               py_in    = py_ff + grmd_pkg::ACC_W'(c_ff);
               state_in = STEP_ADDR;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = dist_ff;
               rsp_hit_in   = hit_ff;
               rsp_oog_in   = oog_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ang_ff      <= ang_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      k_ff        <= k_in;
      dist_ff     <= dist_in;
      hit_ff      <= hit_in;
      oog_ff      <= oog_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_oog_ff  <= rsp_oog_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.distance    = rsp_dist_ff;
   assign rsp_ch.hit_wall    = rsp_hit_ff;
   assign rsp_ch.out_of_grid = rsp_oog_ff;

`ifndef NO_ASSERTIONS
   a_stop_reason_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_oog_ff))
      else $error("result reports both a wall hit and leaving the grid");

   a_result_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == DONE))
      else $error("result register loaded outside the done state");
`endif

endmodule

`default_nettype wire
